@@ rtl/nearest_vertex_radius_histogram_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest vertex radius histogram
// Concurrent property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VERTEX_RADIUS_HISTOGRAM_DEFINES_SVH
`define NEAREST_VERTEX_RADIUS_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NVRH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nvrh: same-cycle property violated");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NVRH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nvrh: next-cycle property violated");

`endif

@@ rtl/nvrh_pkg.sv @@
// ----------------------------------------------------------------------------
// Nearest vertex radius histogram package
// Widths, request codes, sequencer steps and the control store.
// ----------------------------------------------------------------------------
package nvrh_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int BIN_DEPTH    = MAX_VERTICES + 1;
   localparam int VADDR_W      = $clog2(MAX_VERTICES);
   localparam int INDEX_W      = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 24;
   localparam int COUNT_W      = 32;
   localparam int RADIUS_W     = 24;
   localparam int R2_W         = 2 * RADIUS_W;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SQ_W         = 2 * DIFF_W;
   localparam int DIST_W       = SQ_W + 1;
   localparam int REQ_DATA_W   = ((INDEX_W + 2 * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((INDEX_W + COUNT_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int RADIUS_RESET = 1000;

   // register select from paddr bit 2
   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_MATCH_RADIUS = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      STEP_CLEAR    = 4'd0,
      STEP_IDLE     = 4'd1,
      STEP_QSETUP   = 4'd2,
      STEP_SCAN     = 4'd3,
      STEP_DRAIN1   = 4'd4,
      STEP_DRAIN2   = 4'd5,
      STEP_DRAIN3   = 4'd6,
      STEP_BIN_RD   = 4'd7,
      STEP_BIN_WR   = 4'd8,
      STEP_READ     = 4'd9,
      STEP_READ_OUT = 4'd10
   } step_type;

   typedef enum logic [2:0] {
      JMP_NEXT        = 3'd0,
      JMP_ALWAYS      = 3'd1,
      JMP_CLR_MORE    = 3'd2,
      JMP_SCAN_MORE   = 3'd3,
      JMP_NONE_LOADED = 3'd4,
      JMP_DISPATCH    = 3'd5
   } jmp_type;

   typedef struct packed {
      logic     accept;
      logic     clr_wr;
      logic     q_setup;
      logic     scan_issue;
      logic     bin_query_rd;
      logic     bin_query_wr;
      logic     bin_req_rd;
      logic     rsp_read;
      jmp_type  jmp;
      step_type target;
   } ctrl_type;

   // Control store: one word per sequencer step.
   function automatic ctrl_type ucode_word(input step_type step);
      ctrl_type word;
      word        = '0;
      word.jmp    = JMP_NEXT;
      word.target = STEP_IDLE;
      unique case (step)
         STEP_CLEAR: begin
            word.clr_wr = 1'b1;
            word.jmp    = JMP_CLR_MORE;
            word.target = STEP_CLEAR;
         end
         STEP_IDLE: begin
            word.accept = 1'b1;
            word.jmp    = JMP_DISPATCH;
            word.target = STEP_IDLE;
         end
         STEP_QSETUP: begin
            word.q_setup = 1'b1;
            word.jmp     = JMP_NONE_LOADED;
            word.target  = STEP_BIN_RD;
         end
         STEP_SCAN: begin
            word.scan_issue = 1'b1;
            word.jmp        = JMP_SCAN_MORE;
            word.target     = STEP_SCAN;
         end
         STEP_DRAIN1, STEP_DRAIN2, STEP_DRAIN3: begin
            word.jmp = JMP_NEXT;
         end
         STEP_BIN_RD: begin
            word.bin_query_rd = 1'b1;
         end
         STEP_BIN_WR: begin
            word.bin_query_wr = 1'b1;
            word.jmp          = JMP_ALWAYS;
            word.target       = STEP_IDLE;
         end
         STEP_READ: begin
            word.bin_req_rd = 1'b1;
         end
         STEP_READ_OUT: begin
            word.rsp_read = 1'b1;
            word.jmp      = JMP_ALWAYS;
            word.target   = STEP_IDLE;
         end
         default: begin
            word.jmp    = JMP_ALWAYS;
            word.target = STEP_IDLE;
         end
      endcase
      return word;
   endfunction

endpackage

@@ rtl/nearest_vertex_radius_histogram.sv @@
// ----------------------------------------------------------------------------
// Nearest vertex radius histogram
// Brute-force nearest vertex search over a loaded table, with a saturating
// histogram of query results, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | contents
//  req_     | in        | tvalid/tready        | load vertex, query point, read bin
//  rsp_     | out       | tvalid/tready        | one result per request
//  csr_     | in/out    | psel/penable/pready  | vertex_count, match_radius
//
//  Load and no-op results register at the accept edge. A query scans up to
//  vertex_count vertices (capped at 4096; none scanned when it is zero): the
//  scan loop reads one vertex per cycle and feeds a four-stage distance
//  pipeline, then one bin read and write. After reset a clearing pass
//  zeroes the 4097 bins; no request is accepted then. A stalled result holds
//  the next accept.
// ----------------------------------------------------------------------------
module nearest_vertex_radius_histogram
   import nvrh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [12:0] vertex_index, [36:13] coord_x, [60:37] coord_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [12:0] nearest_vertex, [44:13] bin_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] matched
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration
   logic [INDEX_W-1:0]  vertex_count_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic                csr_wr;

   // sequencer
   step_type            step_ff, step_in;
   ctrl_type            cw;
   logic                accept_fire;
   req_kind_type        req_kind;
   logic [INDEX_W-1:0]  req_index;
   logic [COORD_W-1:0]  req_x, req_y;

   // request hold
   logic [INDEX_W-1:0]  idx_ff;
   logic [COORD_W-1:0]  qx_ff, qy_ff;

   // memories
   logic [COORD_W-1:0]  vertex_x_mem [MAX_VERTICES];
   logic [COORD_W-1:0]  vertex_y_mem [MAX_VERTICES];
   logic [COUNT_W-1:0]  bin_mem [BIN_DEPTH];

   // scan pipeline
   logic [INDEX_W-1:0]  n_eff;
   logic [INDEX_W-1:0]  scan_idx_ff;
   logic                v0_ff, v1_ff, v2_ff;
   logic [INDEX_W-1:0]  idx0_ff, idx1_ff, idx2_ff;
   logic [COORD_W-1:0]  vx_rd_ff, vy_rd_ff;
   logic [DIFF_W-1:0]   diff_x, diff_y;
   logic [DIFF_W-1:0]   dx_ff, dy_ff;
   logic [SQ_W-1:0]     sq_x_ff, sq_y_ff;
   logic [DIST_W-1:0]   sum_sq;
   logic [DIST_W-1:0]   best_d_ff;
   logic [INDEX_W-1:0]  best_ff;
   logic                found_ff;
   logic [R2_W-1:0]     r2_ff;
   logic                hit;

   // bins
   logic [INDEX_W-1:0]  clr_idx_ff;
   logic [INDEX_W-1:0]  bin_raddr;
   logic [COUNT_W-1:0]  bin_rd_ff;
   logic [INDEX_W-1:0]  bin_sel_ff;
   logic                matched_ff;
   logic [COUNT_W-1:0]  bin_next;
   logic                bin_we;
   logic [INDEX_W-1:0]  bin_waddr;
   logic [COUNT_W-1:0]  bin_wdata;

   // result register
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                rsp_matched_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_MATCH_RADIUS) ? CSR_DATA_W'(radius_ff)
                                                          : CSR_DATA_W'(vertex_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         radius_ff       <= RADIUS_W'(RADIUS_RESET);
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_VERTEX_COUNT) begin
            vertex_count_ff <= csr_pwdata[INDEX_W-1:0];
         end else begin
            radius_ff <= csr_pwdata[RADIUS_W-1:0];
         end
      end
   end

   // ---------------- sequencer ----------------
   assign req_kind  = req_kind_type'(req_tuser);
   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_x     = req_tdata[INDEX_W +: COORD_W];
   assign req_y     = req_tdata[INDEX_W + COORD_W +: COORD_W];

   assign n_eff = (vertex_count_ff > INDEX_W'(MAX_VERTICES)) ? INDEX_W'(MAX_VERTICES)
                                                             : vertex_count_ff;

   // control outputs of the current step
   always_comb begin
      cw          = ucode_word(step_ff);
      req_tready  = cw.accept && (!rsp_valid_ff || rsp_tready);
      accept_fire = req_tvalid && req_tready;
   end

   // next step
   always_comb begin
      step_in = step_type'(step_ff + 4'd1);
      unique case (cw.jmp)
         JMP_NEXT:   step_in = step_type'(step_ff + 4'd1);
         JMP_ALWAYS: step_in = cw.target;
         JMP_CLR_MORE: begin
            if (clr_idx_ff != INDEX_W'(MAX_VERTICES)) begin
               step_in = cw.target;
            end
         end
         JMP_SCAN_MORE: begin
            if (scan_idx_ff != n_eff) begin
               step_in = cw.target;
            end
         end
         JMP_NONE_LOADED: begin
            if (n_eff == '0) begin
               step_in = cw.target;
            end
         end
         JMP_DISPATCH: begin
            step_in = cw.target;
            if (accept_fire && req_kind == REQ_QUERY) begin
               step_in = STEP_QSETUP;
            end else if (accept_fire && req_kind == REQ_READ) begin
               step_in = STEP_READ;
            end
         end
         default: step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   // hold request fields
   always_ff @(posedge clock) begin
      if (accept_fire) begin
         idx_ff <= req_index;
         qx_ff  <= req_x;
         qy_ff  <= req_y;
      end
   end

   // ---------------- vertex memory ----------------
   always_ff @(posedge clock) begin
      if (accept_fire && req_kind == REQ_LOAD && req_index != '0 &&
          req_index <= INDEX_W'(MAX_VERTICES)) begin
         vertex_x_mem[req_index[VADDR_W-1:0]] <= req_x;
         vertex_y_mem[req_index[VADDR_W-1:0]] <= req_y;
      end
      vx_rd_ff <= vertex_x_mem[scan_idx_ff[VADDR_W-1:0]];
      vy_rd_ff <= vertex_y_mem[scan_idx_ff[VADDR_W-1:0]];
   end

   // ---------------- distance pipeline ----------------
   always_comb begin
      diff_x = {vx_rd_ff[COORD_W-1], vx_rd_ff} - {qx_ff[COORD_W-1], qx_ff};
      diff_y = {vy_rd_ff[COORD_W-1], vy_rd_ff} - {qy_ff[COORD_W-1], qy_ff};
      sum_sq = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff);
      hit    = found_ff && (best_d_ff <= DIST_W'(r2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         v0_ff <= cw.scan_issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         if (cw.q_setup) begin
            found_ff <= 1'b0;
         end else if (v2_ff && (!found_ff || sum_sq < best_d_ff)) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cw.q_setup) begin
         scan_idx_ff <= INDEX_W'(1);
         r2_ff       <= R2_W'(radius_ff) * R2_W'(radius_ff);
      end else if (cw.scan_issue) begin
         scan_idx_ff <= scan_idx_ff + INDEX_W'(1);
      end
      idx0_ff <= scan_idx_ff;
      idx1_ff <= idx0_ff;
      idx2_ff <= idx1_ff;
      // absolute differences
      dx_ff   <= diff_x[DIFF_W-1] ? (~diff_x + DIFF_W'(1)) : diff_x;
      dy_ff   <= diff_y[DIFF_W-1] ? (~diff_y + DIFF_W'(1)) : diff_y;
      sq_x_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sq_y_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      // strict less-than keeps the lowest index on a tie
      if (v2_ff && (!found_ff || sum_sq < best_d_ff)) begin
         best_d_ff <= sum_sq;
         best_ff   <= idx2_ff;
      end
   end

   // ---------------- bin memory ----------------
   always_comb begin
      bin_raddr = '0;
      if (cw.bin_query_rd && hit) begin
         bin_raddr = best_ff;
      end else if (cw.bin_req_rd && idx_ff <= INDEX_W'(MAX_VERTICES)) begin
         bin_raddr = idx_ff;
      end
      // saturate at all ones
      bin_next  = (&bin_rd_ff) ? bin_rd_ff : bin_rd_ff + COUNT_W'(1);
      bin_we    = cw.clr_wr || cw.bin_query_wr;
      bin_waddr = cw.clr_wr ? clr_idx_ff : bin_sel_ff;
      bin_wdata = cw.clr_wr ? '0 : bin_next;
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      bin_rd_ff <= bin_mem[bin_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cw.clr_wr) begin
         clr_idx_ff <= clr_idx_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cw.bin_query_rd) begin
         bin_sel_ff <= bin_raddr;
         matched_ff <= hit;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((accept_fire && (req_kind == REQ_LOAD || req_kind == REQ_NOP)) ||
                   cw.bin_query_wr || cw.rsp_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_fire && (req_kind == REQ_LOAD || req_kind == REQ_NOP)) begin
         rsp_index_ff   <= (req_kind == REQ_LOAD) ? req_index : '0;
         rsp_matched_ff <= 1'b0;
         rsp_count_ff   <= '0;
      end else if (cw.bin_query_wr) begin
         rsp_index_ff   <= bin_sel_ff;
         rsp_matched_ff <= matched_ff;
         rsp_count_ff   <= bin_next;
      end else if (cw.rsp_read) begin
         rsp_index_ff   <= idx_ff;
         rsp_matched_ff <= 1'b0;
         rsp_count_ff   <= (idx_ff <= INDEX_W'(MAX_VERTICES)) ? bin_rd_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_matched_ff;

endmodule

@@ rtl/nvrh_checker.sv @@
// ----------------------------------------------------------------------------
// Nearest vertex radius histogram port checker
// Watches the top level's ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
`include "nearest_vertex_radius_histogram_defines.svh"

module nvrh_checker
   import nvrh_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   // a held result keeps its payload
   `NVRH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // never take a request while an untaken result blocks the output register
   `NVRH_ASSERT_NOW(a_no_overrun, clock, reset, req_tready, !rsp_tvalid || rsp_tready)

   // bins are being cleared right after reset
   `NVRH_ASSERT_NOW(a_clear_after_reset, clock, reset, $fell(reset), !req_tready)

   // a match always names a real vertex
   `NVRH_ASSERT_NOW(a_match_index, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[INDEX_W-1:0] != '0)

endmodule

bind nearest_vertex_radius_histogram nvrh_checker u_nvrh_checker (.*);

@@ sim/nearest_vertex_radius_histogram_tb.sv @@
// ----------------------------------------------------------------------------
// Nearest vertex radius histogram testbench
// Drives load, query, read and no-op requests through the stream ports,
// predicts every result from a local copy of the vertex table, the match
// radius and the bin counts, and checks each result field by field. Runs
// directed corner cases, a small loaded table and random traffic under
// several sender and receiver pacing patterns.
// ----------------------------------------------------------------------------
module nearest_vertex_radius_histogram_tb;
   import nvrh_pkg::*;

   localparam int RUN_LIMIT = 600000;
   localparam int RAND_VERTICES = 16;
   localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
   localparam int COORD_MIN = -(2 ** (COORD_W - 1));
   localparam logic [CSR_ADDR_W-1:0] ADDR_VERTEX_COUNT = {CSR_VERTEX_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_MATCH_RADIUS = {CSR_MATCH_RADIUS, 2'b00};
   localparam int INDEX_ALL_ONES = 2 ** INDEX_W - 1;

   typedef enum int {
      PACE_FREE,
      PACE_SENDER,
      PACE_RECEIVER,
      PACE_BOTH
   } pace_type;

   typedef struct packed {
      logic [INDEX_W-1:0] nearest;
      logic               matched;
      logic [COUNT_W-1:0] count;
   } hist_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = REQ_NOP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // local copy of the block's state
   logic signed [COORD_W-1:0] vtx_x [1:MAX_VERTICES];
   logic signed [COORD_W-1:0] vtx_y [1:MAX_VERTICES];
   logic [COUNT_W-1:0]        bin_tally [0:MAX_VERTICES];
   logic [INDEX_W-1:0]        scan_count_q;
   logic [RADIUS_W-1:0]       radius_q;

   hist_result_type awaited_results[$];
   hist_result_type seen_result;
   hist_result_type want_result;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;

   nearest_vertex_radius_histogram dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result.nearest = rsp_tdata[INDEX_W-1:0];
         seen_result.matched = rsp_tuser[0];
         seen_result.count   = rsp_tdata[INDEX_W +: COUNT_W];
         if (awaited_results.size() == 0) begin
            $error("unexpected result transaction: nearest_vertex %0d", seen_result.nearest);
            fail_count++;
         end else begin
            want_result = awaited_results.pop_front();
            if (seen_result.nearest !== want_result.nearest) begin
               $error("nearest_vertex: expected %0d, got %0d",
                      want_result.nearest, seen_result.nearest);
               fail_count++;
            end
            if (seen_result.matched !== want_result.matched) begin
               $error("matched: expected %0d, got %0d",
                      want_result.matched, seen_result.matched);
               fail_count++;
            end
            if (seen_result.count !== want_result.count) begin
               $error("bin_count: expected %0d, got %0d",
                      want_result.count, seen_result.count);
               fail_count++;
            end
         end
      end
   end

   // Vertex load, nearest vertex search with histogram update, or bin read for one request.
   function automatic hist_result_type histogram_outcome(req_kind_type kind,
                                                         logic [INDEX_W-1:0] idx,
                                                         logic signed [COORD_W-1:0] px,
                                                         logic signed [COORD_W-1:0] py);
      hist_result_type r;
      int              n;
      int              best;
      longint          dx;
      longint          dy;
      longint          sum_sq;
      longint          best_dist;
      longint          radius_sq;
      r = '0;
      case (kind)
         REQ_LOAD: begin
            if (idx >= 1 && idx <= MAX_VERTICES) begin
               vtx_x[idx] = px;
               vtx_y[idx] = py;
            end
            r.nearest = idx;
         end
         REQ_QUERY: begin
            n = (scan_count_q > MAX_VERTICES) ? MAX_VERTICES : int'(scan_count_q);
            best = 0;
            best_dist = 0;
            radius_sq = longint'(radius_q) * longint'(radius_q);
            for (int i = 1; i <= n; i++) begin
               dx = longint'(vtx_x[i]) - longint'(px);
               dy = longint'(vtx_y[i]) - longint'(py);
               sum_sq = dx * dx + dy * dy;
               // strict less-than keeps the lowest index on a tie
               if (best == 0 || sum_sq < best_dist) begin
                  best = i;
                  best_dist = sum_sq;
               end
            end
            if (best_dist > radius_sq)
               best = 0;
            if (bin_tally[best] != '1)
               bin_tally[best] = bin_tally[best] + COUNT_W'(1);
            r.nearest = best[INDEX_W-1:0];
            r.matched = (best != 0);
            r.count   = bin_tally[best];
         end
         REQ_READ: begin
            r.nearest = idx;
            if (idx <= MAX_VERTICES)
               r.count = bin_tally[idx];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic int clamp_coord(longint v);
      if (v > COORD_MAX)
         return COORD_MAX;
      if (v < COORD_MIN)
         return COORD_MIN;
      return int'(v);
   endfunction

   function automatic int random_coord();
      logic [31:0] v;
      v = $urandom();
      return int'(signed'(v[COORD_W-1:0]));
   endfunction

   task automatic set_pace(pace_type pace);
      begin
         sender_idle_pct    = (pace == PACE_SENDER) ? 60 : (pace == PACE_BOTH) ? 16 : 0;
         receiver_stall_pct = (pace == PACE_RECEIVER) ? 60 : (pace == PACE_BOTH) ? 16 : 0;
      end
   endtask

   // Predict on drive: a driven request is held until it is accepted.
   task automatic send_request(req_kind_type kind, int idx, int px, int py);
      int                        gap;
      logic [REQ_DATA_W-1:0]     word;
      logic [INDEX_W-1:0]        idx_bits;
      logic signed [COORD_W-1:0] x_bits;
      logic signed [COORD_W-1:0] y_bits;
      begin
         gap = 0;
         while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
         idx_bits = idx[INDEX_W-1:0];
         x_bits = px[COORD_W-1:0];
         y_bits = py[COORD_W-1:0];
         word = '0;
         word[INDEX_W-1:0] = idx_bits;
         word[INDEX_W +: COORD_W] = x_bits;
         word[INDEX_W + COORD_W +: COORD_W] = y_bits;
         @(negedge clock);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tuser  <= kind;
         req_tdata  <= word;
         awaited_results = {awaited_results,
                            histogram_outcome(kind, idx_bits, x_bits, y_bits)};
         do @(posedge clock); while (!req_tready);
      end
   endtask

   // Drop valid and hold until every expected result has come.
   task automatic settle_idle(int extra);
      begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (awaited_results.size() != 0)
            @(posedge clock);
         repeat (extra) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      begin
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= addr;
         csr_pwdata  <= data;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (addr == ADDR_VERTEX_COUNT)
            scan_count_q = data[INDEX_W-1:0];
         else if (addr == ADDR_MATCH_RADIUS)
            radius_q = data[RADIUS_W-1:0];
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   task automatic csr_readback(logic [CSR_ADDR_W-1:0] addr);
      logic [CSR_DATA_W-1:0] want;
      begin
         want = (addr == ADDR_VERTEX_COUNT) ? CSR_DATA_W'(scan_count_q)
                                            : CSR_DATA_W'(radius_q);
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= addr;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== want) begin
            $error("csr_prdata at %0d: expected %0d, got %0d", addr, want, csr_prdata);
            fail_count++;
         end
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   // Junk in the unused upper bits must be dropped by the registers.
   task automatic apply_setting(int vcount, int radius);
      logic [CSR_DATA_W-1:0] data;
      begin
         settle_idle(8);
         data = $urandom();
         data[INDEX_W-1:0] = vcount[INDEX_W-1:0];
         csr_write(ADDR_VERTEX_COUNT, data);
         data = $urandom();
         data[RADIUS_W-1:0] = radius[RADIUS_W-1:0];
         csr_write(ADDR_MATCH_RADIUS, data);
         csr_readback(ADDR_VERTEX_COUNT);
         csr_readback(ADDR_MATCH_RADIUS);
      end
   endtask

   task automatic send_query_near(int j);
      longint spread;
      longint ox;
      longint oy;
      begin
         spread = longint'(radius_q) + 1;
         ox = longint'($urandom_range(2 * spread)) - spread;
         oy = longint'($urandom_range(2 * spread)) - spread;
         send_request(REQ_QUERY, '0, clamp_coord(longint'(vtx_x[j]) + ox),
                      clamp_coord(longint'(vtx_y[j]) + oy));
      end
   endtask

   task automatic test_reset_defaults();
      begin
         csr_readback(ADDR_VERTEX_COUNT);
         csr_readback(ADDR_MATCH_RADIUS);
      end
   endtask

   task automatic test_directed_cases();
      begin
         set_pace(PACE_FREE);
         // nothing loaded: a query misses
         send_request(REQ_QUERY, '0, 0, 0);
         send_request(REQ_READ, '0, 0, 0);
         // loads outside 1..MAX_VERTICES are ignored
         send_request(REQ_LOAD, '0, 5, 5);
         send_request(REQ_LOAD, INDEX_ALL_ONES, -1, -1);
         send_request(REQ_LOAD, MAX_VERTICES + 1, 7, 7);
         send_request(REQ_LOAD, 1, COORD_MIN, COORD_MIN);
         send_request(REQ_LOAD, 2, COORD_MAX, COORD_MAX);
         send_request(REQ_LOAD, 3, 0, 0);
         send_request(REQ_LOAD, 4, 0, 0);
         send_request(REQ_LOAD, MAX_VERTICES, COORD_MAX, COORD_MIN);
         apply_setting(4, RADIUS_RESET);
         send_request(REQ_QUERY, '0, 0, 0);             // tie between 3 and 4
         send_request(REQ_QUERY, '0, 600, 800);         // exactly on the radius
         send_request(REQ_QUERY, '0, 600, 801);         // just outside
         send_request(REQ_QUERY, '0, COORD_MAX, COORD_MAX);
         send_request(REQ_QUERY, '0, COORD_MIN, COORD_MIN);
         send_request(REQ_QUERY, '0, COORD_MIN, COORD_MAX);
         send_request(REQ_READ, 3, 0, 0);
         send_request(REQ_READ, MAX_VERTICES, 0, 0);
         send_request(REQ_READ, MAX_VERTICES + 1, 0, 0);
         send_request(REQ_READ, INDEX_ALL_ONES, -1, -1);
         send_request(REQ_NOP, 'h1ABC, -2, 3);
         apply_setting(4, 0);
         send_request(REQ_QUERY, '0, 0, 0);
         send_request(REQ_QUERY, '0, 1, 0);
         apply_setting(4, 2 ** RADIUS_W - 1);
         send_request(REQ_QUERY, '0, COORD_MIN, COORD_MAX);
         apply_setting(0, 2 ** RADIUS_W - 1);
         send_request(REQ_QUERY, '0, 3, 3);
      end
   endtask

   // Load the vertices that random traffic scans, close together.
   task automatic test_load_table();
      begin
         set_pace(PACE_FREE);
         for (int i = 1; i <= RAND_VERTICES; i++)
            send_request(REQ_LOAD, i, int'($urandom_range(20000)) - 10000,
                         int'($urandom_range(20000)) - 10000);
      end
   endtask

   task automatic test_random_traffic(pace_type pace, int items);
      int n;
      int radius;
      int pick;
      int j;
      begin
         n = $urandom_range(1, RAND_VERTICES);
         case ($urandom_range(4))
            0: radius = 0;
            1: radius = RADIUS_RESET;
            2: radius = $urandom_range(2 ** RADIUS_W - 1);
            3: radius = 2 ** RADIUS_W - 1;
            default: radius = $urandom_range(50000);
         endcase
         apply_setting(n, radius);
         set_pace(pace);
         for (int k = 0; k < items; k++) begin
            pick = $urandom_range(99);
            j = $urandom_range(1, n);
            if (pick < 15) begin
               case ($urandom_range(9))
                  0: send_request(REQ_LOAD, '0, random_coord(), random_coord());
                  1: send_request(REQ_LOAD, $urandom_range(MAX_VERTICES + 1, 2 ** INDEX_W - 1),
                                  random_coord(), random_coord());
                  2: send_request(REQ_LOAD, $urandom_range(1, MAX_VERTICES),
                                  random_coord(), random_coord());
                  3, 4: send_request(REQ_LOAD, j, random_coord(), random_coord());
                  default: send_request(REQ_LOAD, $urandom_range(1, n),
                     clamp_coord(longint'(vtx_x[j]) + $urandom_range(2000) - 1000),
                     clamp_coord(longint'(vtx_y[j]) + $urandom_range(2000) - 1000));
               endcase
            end else if (pick < 75) begin
               if ($urandom_range(9) < 7)
                  send_query_near(j);
               else
                  send_request(REQ_QUERY, $urandom(), random_coord(), random_coord());
            end else if (pick < 95) begin
               if ($urandom_range(3) == 0)
                  send_request(REQ_READ, $urandom(), random_coord(), random_coord());
               else
                  send_request(REQ_READ, $urandom_range(0, n), random_coord(), random_coord());
            end else begin
               send_request(REQ_NOP, $urandom(), random_coord(), random_coord());
            end
            if (k == items / 2 || $urandom_range(19) == 0)
               settle_idle(0);
         end
      end
   endtask

   initial begin
      for (int i = 0; i <= MAX_VERTICES; i++)
         bin_tally[i] = '0;
      scan_count_q = '0;
      radius_q = RADIUS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_load_table();
      test_random_traffic(PACE_FREE, 25);
      test_random_traffic(PACE_SENDER, 25);
      test_random_traffic(PACE_RECEIVER, 25);
      test_random_traffic(PACE_BOTH, 25);

      settle_idle(16);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
